// ===== hw/rtl/acm_pkg.sv =====
`timescale 1ns / 1ps
package acm_pkg;

    localparam int DEF_MAX_NODES     = 1024;
    localparam int DEF_ALPHABET_SIZE = 26;
    localparam int MAX_PATTERNS      = 64;
    localparam int PAT_W             = 6;
    localparam int POS_W             = 16;

    // Pattern reference as stored: bit 6 set means no pattern
    localparam logic [PAT_W:0] PAT_NONE = 7'h40;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BUILD = 2'd1;
    localparam logic [1:0] OP_TEXT  = 2'd2;

    typedef enum logic [2:0] {
        STAT_MATCH     = 3'd0,
        STAT_NO_MATCH  = 3'd1,
        STAT_DONE      = 3'd2,
        STAT_OVERFLOW  = 3'd3,
        STAT_NOT_BUILT = 3'd4
    } t_status;

    typedef struct packed {
        logic    clr_step;
        logic    accept;
        logic    bf_init;
        logic    tx_start;
        logic    sc_root;
        logic    ld_read;
        logic    ld_update;
        logic    ld_pat;
        logic    bf_pop;
        logic    bf_node;
        logic    bf_fail;
        logic    bf_read;
        logic    bf_eval;
        logic    bf_link;
        logic    sc_read;
        logic    sc_node;
        logic    sc_end;
        logic    walk_adv;
        logic    emit;
        logic    last;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic in_char_ok;
        logic built;
        logic ovf;
        logic ld_more;
        logic q_empty;
        logic ed_zero;
        logic i_last;
        logic end_none;
        logic chain_none;
        logic out_free;
        logic clr_done;
    } t_sts;

endpackage

// ===== hw/rtl/aho_corasick_multi_pattern_matcher.sv =====
`timescale 1ns / 1ps
// Pattern character: states LD_RD and LD_CHK, then LD_PAT when it ends a pattern; an ignored
// one leaves the controller idle. Text character: SC_RD, SC_NODE and SC_END, then WALK along the
// output chain, one match result per cycle while the output is not stalled, or EMIT for no match
// (EMIT alone before build or for an out-of-range letter). Build: BF_POP, BF_NODE and BF_FAIL per
// trie node, then BF_RD and BF_EVAL per node and letter, plus BF_LINK for an existing edge.
// One item in work at a time. Reset: synchronous; a clearing pass sweeps the tables.
module aho_corasick_multi_pattern_matcher #(
    parameter int MAX_NODES     = acm_pkg::DEF_MAX_NODES,
    parameter int ALPHABET_SIZE = acm_pkg::DEF_ALPHABET_SIZE
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_opcode,
    input  logic [4:0]                i_char_code,
    input  logic                      i_pattern_end,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [2:0]                o_status,
    output logic [acm_pkg::PAT_W-1:0] o_pattern_id,
    output logic [acm_pkg::POS_W-1:0] o_start_position,
    output logic [acm_pkg::POS_W-1:0] o_end_position,
    output logic                      o_last_result
);

    acm_pkg::t_cmd w_cmd;
    acm_pkg::t_sts w_sts;

    acm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    acm_datapath #(
        .MAX_NODES     (MAX_NODES),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_char_code      (i_char_code),
        .i_pattern_end    (i_pattern_end),
        .i_out_stall      (i_out_stall),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_pattern_id     (o_pattern_id),
        .o_start_position (o_start_position),
        .o_end_position   (o_end_position),
        .o_last_result    (o_last_result)
    );

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_sts.out_free)
        else $error("result loaded while output register is occupied");

    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> w_sts.clr_done)
        else $error("input taken before clearing pass finished");

    a_not_built_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == acm_pkg::STAT_NOT_BUILT) |->
            (o_end_position == '0 && o_last_result))
        else $error("not-built result carries a position or is not last");

    a_no_match_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == acm_pkg::STAT_NO_MATCH) |-> o_last_result)
        else $error("no-match result not marked last");

endmodule

// ===== hw/rtl/acm_ctrl.sv =====
`timescale 1ns / 1ps
module acm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_opcode,
    input  acm_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output acm_pkg::t_cmd o_cmd
);

    typedef enum logic [15:0] {
        S_CLEAR   = 16'h0001,
        S_IDLE    = 16'h0002,
        S_LD_RD   = 16'h0004,
        S_LD_CHK  = 16'h0008,
        S_LD_PAT  = 16'h0010,
        S_BF_POP  = 16'h0020,
        S_BF_NODE = 16'h0040,
        S_BF_FAIL = 16'h0080,
        S_BF_RD   = 16'h0100,
        S_BF_EVAL = 16'h0200,
        S_BF_LINK = 16'h0400,
        S_SC_RD   = 16'h0800,
        S_SC_NODE = 16'h1000,
        S_SC_END  = 16'h2000,
        S_WALK    = 16'h4000,
        S_EMIT    = 16'h8000
    } t_state;

    t_state           r_state, n_state;
    acm_pkg::t_status r_code, n_code;
    acm_pkg::t_cmd    w_cmd;

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        w_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.accept = 1'b1;
                    unique case (i_opcode)
                        acm_pkg::OP_LOAD: begin
                            if (!i_sts.built && !i_sts.ovf && i_sts.in_char_ok)
                                n_state = S_LD_RD;
                        end
                        acm_pkg::OP_BUILD: begin
                            if (i_sts.built) begin
                                n_code  = i_sts.ovf ? acm_pkg::STAT_OVERFLOW
                                                    : acm_pkg::STAT_DONE;
                                n_state = S_EMIT;
                            end else begin
                                w_cmd.bf_init = 1'b1;
                                n_state       = S_BF_POP;
                            end
                        end
                        acm_pkg::OP_TEXT: begin
                            if (!i_sts.built) begin
                                n_code  = acm_pkg::STAT_NOT_BUILT;
                                n_state = S_EMIT;
                            end else begin
                                w_cmd.tx_start = 1'b1;
                                if (i_sts.in_char_ok) begin
                                    n_state = S_SC_RD;
                                end else begin
                                    w_cmd.sc_root = 1'b1;
                                    n_code        = acm_pkg::STAT_NO_MATCH;
                                    n_state       = S_EMIT;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LD_RD: begin
                w_cmd.ld_read = 1'b1;
                n_state       = S_LD_CHK;
            end
            S_LD_CHK: begin
                w_cmd.ld_update = 1'b1;
                n_state         = i_sts.ld_more ? S_LD_PAT : S_IDLE;
            end
            S_LD_PAT: begin
                w_cmd.ld_pat = 1'b1;
                n_state      = S_IDLE;
            end
            S_BF_POP: begin
                w_cmd.bf_pop = 1'b1;
                if (i_sts.q_empty) begin
                    n_code  = i_sts.ovf ? acm_pkg::STAT_OVERFLOW : acm_pkg::STAT_DONE;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_BF_NODE;
                end
            end
            S_BF_NODE: begin
                w_cmd.bf_node = 1'b1;
                n_state       = S_BF_FAIL;
            end
            S_BF_FAIL: begin
                w_cmd.bf_fail = 1'b1;
                n_state       = S_BF_RD;
            end
            S_BF_RD: begin
                w_cmd.bf_read = 1'b1;
                n_state       = S_BF_EVAL;
            end
            S_BF_EVAL: begin
                w_cmd.bf_eval = 1'b1;
                if (!i_sts.ed_zero) n_state = S_BF_LINK;
                else                n_state = i_sts.i_last ? S_BF_POP : S_BF_RD;
            end
            S_BF_LINK: begin
                w_cmd.bf_link = 1'b1;
                n_state       = i_sts.i_last ? S_BF_POP : S_BF_RD;
            end
            S_SC_RD: begin
                w_cmd.sc_read = 1'b1;
                n_state       = S_SC_NODE;
            end
            S_SC_NODE: begin
                w_cmd.sc_node = 1'b1;
                n_state       = S_SC_END;
            end
            S_SC_END: begin
                w_cmd.sc_end = 1'b1;
                if (i_sts.end_none) begin
                    n_code  = acm_pkg::STAT_NO_MATCH;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                w_cmd.status = acm_pkg::STAT_MATCH;
                w_cmd.last   = i_sts.chain_none;
                if (i_sts.out_free) begin
                    w_cmd.emit = 1'b1;
                    if (i_sts.chain_none) n_state = S_IDLE;
                    else                  w_cmd.walk_adv = 1'b1;
                end
            end
            S_EMIT: begin
                w_cmd.status = r_code;
                w_cmd.last   = 1'b1;
                if (i_sts.out_free) begin
                    w_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_code  <= acm_pkg::STAT_DONE;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = w_cmd;

endmodule

// ===== hw/rtl/acm_datapath.sv =====
`timescale 1ns / 1ps
module acm_datapath #(
    parameter int MAX_NODES     = acm_pkg::DEF_MAX_NODES,
    parameter int ALPHABET_SIZE = acm_pkg::DEF_ALPHABET_SIZE
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [4:0]                i_char_code,
    input  logic                      i_pattern_end,
    input  logic                      i_out_stall,
    input  acm_pkg::t_cmd             i_cmd,
    output acm_pkg::t_sts             o_sts,
    output logic                      o_out_valid,
    output logic [2:0]                o_status,
    output logic [acm_pkg::PAT_W-1:0] o_pattern_id,
    output logic [acm_pkg::POS_W-1:0] o_start_position,
    output logic [acm_pkg::POS_W-1:0] o_end_position,
    output logic                      o_last_result
);

    localparam int NW    = $clog2(MAX_NODES);
    localparam int CW    = $clog2(ALPHABET_SIZE);
    localparam int TW    = NW + CW;
    localparam int CLR_W = (TW > 6) ? TW : 6;
    localparam int PW    = acm_pkg::PAT_W;
    localparam int QW    = acm_pkg::POS_W;

    // Memories
    logic [NW-1:0] r_trans [2**TW];
    logic [NW-1:0] r_fail  [2**NW];
    logic [PW:0]   r_endp  [2**NW];
    logic [PW:0]   r_first [2**NW];
    logic [PW:0]   r_chain [2**PW];
    logic [NW-1:0] r_len   [2**PW];
    logic [NW-1:0] r_queue [2**NW];

    logic [NW-1:0] r_tr_rda, r_tr_rdb, r_fail_rd, r_len_rd, r_q_rd;
    logic [PW:0]   r_end_rda, r_end_rdb, r_first_rd, r_chain_rd;

    logic          w_tr_we, w_tr_rea, w_tr_reb;
    logic [TW-1:0] w_tr_wa, w_tr_raa, w_tr_rab;
    logic [NW-1:0] w_tr_wd;
    logic          w_fl_we, w_fl_re;
    logic [NW-1:0] w_fl_wa, w_fl_ra, w_fl_wd;
    logic          w_en_we, w_en_rea, w_en_reb;
    logic [NW-1:0] w_en_wa, w_en_raa, w_en_rab;
    logic [PW:0]   w_en_wd;
    logic          w_fp_we, w_fp_re;
    logic [NW-1:0] w_fp_wa, w_fp_ra;
    logic [PW:0]   w_fp_wd;
    logic          w_ch_we, w_ch_re;
    logic [PW-1:0] w_ch_wa, w_ch_ra;
    logic [PW:0]   w_ch_wd;
    logic          w_ln_we;
    logic [PW-1:0] w_ln_wa;
    logic [NW-1:0] w_ln_wd;
    logic          w_q_we, w_q_re;
    logic [NW-1:0] w_q_wa, w_q_ra, w_q_wd;

    // Control and payload registers
    logic [NW:0]      r_node_cnt, n_node_cnt;
    logic [PW:0]      r_pat_cnt, n_pat_cnt;
    logic [NW-1:0]    r_ins_node, n_ins_node;
    logic [NW-1:0]    r_ins_len, n_ins_len;
    logic [NW-1:0]    r_scan, n_scan;
    logic [QW-1:0]    r_text, n_text;
    logic [QW-1:0]    r_pos, n_pos;
    logic             r_built, n_built;
    logic             r_ovf, n_ovf;
    logic [4:0]       r_char, n_char;
    logic             r_end, n_end;
    logic [NW:0]      r_head, n_head;
    logic [NW:0]      r_tail, n_tail;
    logic [NW-1:0]    r_n, n_n;
    logic [NW-1:0]    r_f, n_f;
    logic [CW-1:0]    r_i, n_i;
    logic [NW-1:0]    r_ed, n_ed;
    logic [PW-1:0]    r_p, n_p;
    logic [NW-1:0]    r_nxt, n_nxt;
    logic [CLR_W-1:0] r_clr, n_clr;
    logic             r_out_valid, n_out_valid;
    acm_pkg::t_status r_out_status, n_out_status;
    logic [PW-1:0]    r_out_id, n_out_id;
    logic [QW-1:0]    r_out_start, n_out_start;
    logic [QW-1:0]    r_out_endp, n_out_endp;
    logic             r_out_last, n_out_last;

    logic [CW-1:0] w_idx;
    logic          w_ld_zero, w_node_full, w_pat_full, w_ld_fail;
    logic [NW-1:0] w_ld_nxt, w_y;
    logic          w_out_free, w_clr_done;

    assign w_idx       = CW'(r_char);
    assign w_ld_zero   = (r_tr_rda == '0);
    assign w_node_full = (r_node_cnt >= (NW+1)'(MAX_NODES));
    assign w_pat_full  = (r_pat_cnt >= (PW+1)'(acm_pkg::MAX_PATTERNS));
    assign w_ld_fail   = w_ld_zero && w_node_full;
    assign w_ld_nxt    = w_ld_zero ? r_node_cnt[NW-1:0] : r_tr_rda;
    assign w_y         = (r_n == '0) ? '0 : r_tr_rdb;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_clr_done  = &r_clr;

    always_comb begin
        w_tr_we = 1'b0; w_tr_wa = '0; w_tr_wd = '0;
        w_tr_rea = 1'b0; w_tr_raa = '0; w_tr_reb = 1'b0; w_tr_rab = '0;
        w_fl_we = 1'b0; w_fl_wa = '0; w_fl_wd = '0; w_fl_re = 1'b0; w_fl_ra = '0;
        w_en_we = 1'b0; w_en_wa = '0; w_en_wd = '0;
        w_en_rea = 1'b0; w_en_raa = '0; w_en_reb = 1'b0; w_en_rab = '0;
        w_fp_we = 1'b0; w_fp_wa = '0; w_fp_wd = '0; w_fp_re = 1'b0; w_fp_ra = '0;
        w_ch_we = 1'b0; w_ch_wa = '0; w_ch_wd = '0; w_ch_re = 1'b0; w_ch_ra = '0;
        w_ln_we = 1'b0; w_ln_wa = '0; w_ln_wd = '0;
        w_q_we = 1'b0; w_q_wa = '0; w_q_wd = '0; w_q_re = 1'b0; w_q_ra = '0;

        n_node_cnt = r_node_cnt; n_pat_cnt = r_pat_cnt;
        n_ins_node = r_ins_node; n_ins_len = r_ins_len;
        n_scan = r_scan; n_text = r_text; n_pos = r_pos;
        n_built = r_built; n_ovf = r_ovf;
        n_char = r_char; n_end = r_end;
        n_head = r_head; n_tail = r_tail;
        n_n = r_n; n_f = r_f; n_i = r_i; n_ed = r_ed;
        n_p = r_p; n_nxt = r_nxt; n_clr = r_clr;
        n_out_status = r_out_status; n_out_id = r_out_id;
        n_out_start = r_out_start; n_out_endp = r_out_endp; n_out_last = r_out_last;
        n_out_valid = r_out_valid && i_out_stall;

        if (i_cmd.clr_step) begin
            // Sweep the transition, failure, end, first and chain memories with the reset contents
            w_tr_we = 1'b1; w_tr_wa = r_clr[TW-1:0];
            w_fl_we = 1'b1; w_fl_wa = r_clr[NW-1:0];
            w_en_we = 1'b1; w_en_wa = r_clr[NW-1:0]; w_en_wd = acm_pkg::PAT_NONE;
            w_fp_we = 1'b1; w_fp_wa = r_clr[NW-1:0]; w_fp_wd = acm_pkg::PAT_NONE;
            w_ch_we = 1'b1; w_ch_wa = r_clr[PW-1:0]; w_ch_wd = acm_pkg::PAT_NONE;
            if (!w_clr_done) n_clr = r_clr + 1'b1;
        end

        if (i_cmd.accept) begin
            n_char = i_char_code;
            n_end  = i_pattern_end;
        end
        if (i_cmd.bf_init) begin
            n_ins_node = '0;
            n_ins_len  = '0;
            w_q_we = 1'b1; w_q_wa = '0; w_q_wd = '0;
            n_head = '0;
            n_tail = (NW+1)'(1);
        end
        if (i_cmd.tx_start) begin
            n_pos  = r_text;
            n_text = r_text + 1'b1;
        end
        if (i_cmd.sc_root) n_scan = '0;

        if (i_cmd.ld_read) begin
            w_tr_rea = 1'b1; w_tr_raa = {r_ins_node, w_idx};
        end
        if (i_cmd.ld_update) begin
            if (w_ld_fail) begin
                n_ovf = 1'b1;
            end else begin
                if (w_ld_zero) begin
                    w_tr_we = 1'b1; w_tr_wa = {r_ins_node, w_idx}; w_tr_wd = w_ld_nxt;
                    n_node_cnt = r_node_cnt + 1'b1;
                end
                n_ins_node = w_ld_nxt;
                n_ins_len  = r_ins_len + 1'b1;
                n_nxt      = w_ld_nxt;
                if (r_end) begin
                    if (w_pat_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        w_en_rea = 1'b1; w_en_raa = w_ld_nxt;
                    end
                end
            end
        end
        if (i_cmd.ld_pat) begin
            w_ln_we = 1'b1; w_ln_wa = r_pat_cnt[PW-1:0]; w_ln_wd = r_ins_len;
            if (r_end_rda[PW]) begin
                w_fp_we = 1'b1; w_fp_wa = r_nxt; w_fp_wd = r_pat_cnt;
            end
            w_ch_we = 1'b1; w_ch_wa = r_pat_cnt[PW-1:0]; w_ch_wd = r_end_rda;
            w_en_we = 1'b1; w_en_wa = r_nxt; w_en_wd = r_pat_cnt;
            n_pat_cnt  = r_pat_cnt + 1'b1;
            n_ins_node = '0;
            n_ins_len  = '0;
        end

        if (i_cmd.bf_pop) begin
            if (r_head == r_tail) begin
                n_built = 1'b1;
            end else begin
                w_q_re = 1'b1; w_q_ra = r_head[NW-1:0];
                n_head = r_head + 1'b1;
            end
        end
        if (i_cmd.bf_node) begin
            n_n = r_q_rd;
            w_fl_re = 1'b1; w_fl_ra = r_q_rd;
            n_i = '0;
        end
        if (i_cmd.bf_fail) n_f = (r_n == '0) ? '0 : r_fail_rd;
        if (i_cmd.bf_read) begin
            w_tr_rea = 1'b1; w_tr_raa = {r_n, r_i};
            w_tr_reb = 1'b1; w_tr_rab = {r_f, r_i};
        end
        if (i_cmd.bf_eval) begin
            if (r_tr_rda == '0) begin
                // Missing edge takes the failure node's edge
                w_tr_we = 1'b1; w_tr_wa = {r_n, r_i}; w_tr_wd = w_y;
                n_i = r_i + 1'b1;
            end else begin
                w_fl_we = 1'b1; w_fl_wa = r_tr_rda; w_fl_wd = w_y;
                w_en_rea = 1'b1; w_en_raa = r_tr_rda;
                w_en_reb = 1'b1; w_en_rab = w_y;
                w_fp_re = 1'b1; w_fp_ra = r_tr_rda;
                w_q_we = 1'b1; w_q_wa = r_tail[NW-1:0]; w_q_wd = r_tr_rda;
                n_tail = r_tail + 1'b1;
                n_ed = r_tr_rda;
            end
        end
        if (i_cmd.bf_link) begin
            // Splice the failure node's output chain behind this node's own
            if (r_end_rda[PW]) begin
                w_en_we = 1'b1; w_en_wa = r_ed; w_en_wd = r_end_rdb;
            end else begin
                w_ch_we = 1'b1; w_ch_wa = r_first_rd[PW-1:0]; w_ch_wd = r_end_rdb;
            end
            n_i = r_i + 1'b1;
        end

        if (i_cmd.sc_read) begin
            w_tr_rea = 1'b1; w_tr_raa = {r_scan, w_idx};
        end
        if (i_cmd.sc_node) begin
            n_scan = r_tr_rda;
            w_en_rea = 1'b1; w_en_raa = r_tr_rda;
        end
        if (i_cmd.sc_end && !r_end_rda[PW]) begin
            w_ch_re = 1'b1; w_ch_ra = r_end_rda[PW-1:0];
            n_p = r_end_rda[PW-1:0];
        end
        if (i_cmd.walk_adv) begin
            w_ch_re = 1'b1; w_ch_ra = r_chain_rd[PW-1:0];
            n_p = r_chain_rd[PW-1:0];
        end

        if (i_cmd.emit) begin
            n_out_valid  = 1'b1;
            n_out_status = i_cmd.status;
            n_out_last   = i_cmd.last;
            n_out_id     = '0;
            n_out_start  = '0;
            n_out_endp   = '0;
            if (i_cmd.status == acm_pkg::STAT_MATCH) begin
                n_out_id    = r_p;
                n_out_start = r_pos - QW'(r_len_rd) + 1'b1;
                n_out_endp  = r_pos;
            end else if (i_cmd.status == acm_pkg::STAT_NO_MATCH) begin
                n_out_endp  = r_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tr_we) r_trans[w_tr_wa] <= w_tr_wd;
        if (w_tr_rea) r_tr_rda <= r_trans[w_tr_raa];
        if (w_tr_reb) r_tr_rdb <= r_trans[w_tr_rab];
    end

    always_ff @(posedge i_clk) begin
        if (w_fl_we) r_fail[w_fl_wa] <= w_fl_wd;
        if (w_fl_re) r_fail_rd <= r_fail[w_fl_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_en_we) r_endp[w_en_wa] <= w_en_wd;
        if (w_en_rea) r_end_rda <= r_endp[w_en_raa];
        if (w_en_reb) r_end_rdb <= r_endp[w_en_rab];
    end

    always_ff @(posedge i_clk) begin
        if (w_fp_we) r_first[w_fp_wa] <= w_fp_wd;
        if (w_fp_re) r_first_rd <= r_first[w_fp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_ch_we) r_chain[w_ch_wa] <= w_ch_wd;
        if (w_ch_re) r_chain_rd <= r_chain[w_ch_ra];
    end

    // Length is read alongside the chain entry
    always_ff @(posedge i_clk) begin
        if (w_ln_we) r_len[w_ln_wa] <= w_ln_wd;
        if (w_ch_re) r_len_rd <= r_len[w_ch_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_q_we) r_queue[w_q_wa] <= w_q_wd;
        if (w_q_re) r_q_rd <= r_queue[w_q_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_cnt  <= (NW+1)'(1);
            r_pat_cnt   <= '0;
            r_ins_node  <= '0;
            r_ins_len   <= '0;
            r_scan      <= '0;
            r_text      <= '0;
            r_built     <= 1'b0;
            r_ovf       <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_node_cnt  <= n_node_cnt;
            r_pat_cnt   <= n_pat_cnt;
            r_ins_node  <= n_ins_node;
            r_ins_len   <= n_ins_len;
            r_scan      <= n_scan;
            r_text      <= n_text;
            r_built     <= n_built;
            r_ovf       <= n_ovf;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_char       <= n_char;
        r_end        <= n_end;
        r_n          <= n_n;
        r_f          <= n_f;
        r_i          <= n_i;
        r_ed         <= n_ed;
        r_p          <= n_p;
        r_nxt        <= n_nxt;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_start  <= n_out_start;
        r_out_endp   <= n_out_endp;
        r_out_last   <= n_out_last;
    end

    always_comb begin
        o_sts            = '0;
        o_sts.in_char_ok = (32'(i_char_code) < 32'(ALPHABET_SIZE));
        o_sts.built      = r_built;
        o_sts.ovf        = r_ovf;
        o_sts.ld_more    = !w_ld_fail && r_end && !w_pat_full;
        o_sts.q_empty    = (r_head == r_tail);
        o_sts.ed_zero    = (r_tr_rda == '0);
        o_sts.i_last     = (r_i == CW'(ALPHABET_SIZE - 1));
        o_sts.end_none   = r_end_rda[PW];
        o_sts.chain_none = r_chain_rd[PW];
        o_sts.out_free   = w_out_free;
        o_sts.clr_done   = w_clr_done;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_pattern_id     = r_out_id;
    assign o_start_position = r_out_start;
    assign o_end_position   = r_out_endp;
    assign o_last_result    = r_out_last;

endmodule

// ===== test/tb_aho_corasick_multi_pattern_matcher.sv =====
`timescale 1ns / 1ps
module tb_aho_corasick_multi_pattern_matcher;

    localparam int NODES   = acm_pkg::DEF_MAX_NODES;
    localparam int LETTERS = acm_pkg::DEF_ALPHABET_SIZE;
    localparam int NPATS   = acm_pkg::MAX_PATTERNS;
    localparam int NO_PAT  = 255;

    typedef struct {
        acm_pkg::t_status status;
        logic [5:0]       pattern_id;
        logic [15:0]      start_pos;
        logic [15:0]      end_pos;
        logic             last;
    } t_match_rec;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_opcode;
    logic [4:0]  i_char_code;
    logic        i_pattern_end;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [5:0]  o_pattern_id;
    logic [15:0] o_start_position;
    logic [15:0] o_end_position;
    logic        o_last_result;

    aho_corasick_multi_pattern_matcher u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_char_code      (i_char_code),
        .i_pattern_end    (i_pattern_end),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_pattern_id     (o_pattern_id),
        .o_start_position (o_start_position),
        .o_end_position   (o_end_position),
        .o_last_result    (o_last_result)
    );

    // Automaton mirror
    int unsigned goto_tbl [NODES*LETTERS];
    int unsigned fail_tbl [NODES];
    int unsigned end_pat [NODES];
    int unsigned first_pat [NODES];
    int unsigned next_pat [NPATS];
    int unsigned pat_len [NPATS];
    int unsigned n_nodes, n_pats, ins_node, ins_len, cur_node, text_pos;
    bit          is_built, is_ovf;

    t_match_rec  match_q[$];
    int          err_cnt;
    int          pats_loaded;
    bit          quiet;
    bit          hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("** aho_corasick_multi_pattern_matcher: FAILED **");
        $finish;
    end

    function automatic void clear_automaton();
        for (int k = 0; k < NODES*LETTERS; k++) goto_tbl[k] = 0;
        for (int k = 0; k < NODES; k++) begin
            fail_tbl[k]  = 0;
            end_pat[k]   = NO_PAT;
            first_pat[k] = NO_PAT;
        end
        for (int k = 0; k < NPATS; k++) begin
            next_pat[k] = NO_PAT;
            pat_len[k]  = 0;
        end
        n_nodes = 1; n_pats = 0; ins_node = 0; ins_len = 0;
        cur_node = 0; text_pos = 0; is_built = 0; is_ovf = 0;
    endfunction

    function automatic void push_rec(acm_pkg::t_status st, int unsigned id, int unsigned sp,
                                     int unsigned ep, bit last);
        t_match_rec r;
        r.status = st; r.pattern_id = id[5:0]; r.start_pos = sp[15:0];
        r.end_pos = ep[15:0]; r.last = last;
        match_q.insert(match_q.size(), r);
    endfunction

    function automatic void add_pattern_char(int unsigned c, bit last);
        int unsigned idx, nxt, j;
        if (is_built || is_ovf || c >= LETTERS) return;
        idx = ins_node * LETTERS + c;
        nxt = goto_tbl[idx];
        if (nxt == 0) begin
            if (n_nodes >= NODES) begin
                is_ovf = 1;
                return;
            end
            nxt = n_nodes++;
            goto_tbl[idx] = nxt;
        end
        ins_node = nxt;
        ins_len++;
        if (!last) return;
        if (n_pats >= NPATS) begin
            is_ovf = 1;
            return;
        end
        j = n_pats++;
        pat_len[j] = ins_len;
        if (end_pat[nxt] == NO_PAT) first_pat[nxt] = j;
        next_pat[j] = end_pat[nxt];
        end_pat[nxt] = j;
        ins_node = 0;
        ins_len = 0;
    endfunction

    function automatic void build_automaton();
        int unsigned fifo[$];
        int unsigned n, ed, y;
        ins_node = 0;
        ins_len = 0;
        fifo.insert(0, 0);
        while (fifo.size() > 0) begin
            n = fifo.pop_front();
            for (int unsigned i = 0; i < LETTERS; i++) begin
                ed = goto_tbl[n*LETTERS + i];
                y = (n == 0) ? 0 : goto_tbl[fail_tbl[n]*LETTERS + i];
                if (ed == 0) begin
                    goto_tbl[n*LETTERS + i] = y;
                end else begin
                    fail_tbl[ed] = y;
                    if (end_pat[ed] == NO_PAT) end_pat[ed] = end_pat[y];
                    else next_pat[first_pat[ed] % NPATS] = end_pat[y];
                    fifo.insert(fifo.size(), ed);
                end
            end
        end
        is_built = 1;
    endfunction

    function automatic void scan_char(int unsigned c);
        int unsigned pos, p;
        int cnt;
        cnt = 0;
        if (!is_built) begin
            push_rec(acm_pkg::STAT_NOT_BUILT, 0, 0, 0, 1);
            return;
        end
        pos = text_pos;
        text_pos = (text_pos + 1) & 16'hFFFF;
        if (c >= LETTERS) begin
            cur_node = 0;
        end else begin
            cur_node = goto_tbl[cur_node*LETTERS + c];
            p = end_pat[cur_node];
            while (p != NO_PAT && p < NPATS && cnt < NPATS) begin
                push_rec(acm_pkg::STAT_MATCH, p, pos - pat_len[p] + 1, pos, 0);
                cnt++;
                p = next_pat[p];
            end
        end
        if (cnt == 0) push_rec(acm_pkg::STAT_NO_MATCH, 0, 0, pos, 1);
        else match_q[match_q.size()-1].last = 1;
    endfunction

    function automatic void predict_item(logic [1:0] op, logic [4:0] c, logic pe);
        case (op)
            acm_pkg::OP_LOAD: add_pattern_char(c, pe);
            acm_pkg::OP_BUILD: begin
                if (!is_built) build_automaton();
                push_rec(is_ovf ? acm_pkg::STAT_OVERFLOW : acm_pkg::STAT_DONE, 0, 0, 0, 1);
            end
            acm_pkg::OP_TEXT: scan_char(c);
            default: ;
        endcase
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (match_q.size() == 0) begin
                $display("%0t unexpected result: status %0d id %0d start %0d end %0d",
                         $time, o_status, o_pattern_id, o_start_position, o_end_position);
                err_cnt++;
            end else begin
                t_match_rec r;
                r = match_q.pop_front();
                if (o_status !== r.status || o_pattern_id !== r.pattern_id ||
                    o_start_position !== r.start_pos || o_end_position !== r.end_pos ||
                    o_last_result !== r.last) begin
                    $display("%0t mismatch: expected st %0d id %0d sp %0d ep %0d last %0d",
                             $time, r.status, r.pattern_id, r.start_pos, r.end_pos, r.last);
                    $display("%0t           actual   st %0d id %0d sp %0d ep %0d last %0d",
                             $time, o_status, o_pattern_id, o_start_position,
                             o_end_position, o_last_result);
                    err_cnt++;
                end
            end
        end
    end

    // Receiver: random stall bursts, or a long hold on request
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [4:0] c, input logic pe);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_char_code   <= c;
        i_pattern_end <= pe;
        do @(posedge i_clk); while (o_in_stall);
        predict_item(op, c, pe);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (match_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_pattern(input string s);
        for (int k = 0; k < s.len(); k++)
            send_item(acm_pkg::OP_LOAD, 5'(s[k] - "a"), k == s.len() - 1);
        pats_loaded++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_item(acm_pkg::OP_TEXT, 5'(s[k] - "a"), 1'b0);
    endtask

    function automatic logic [4:0] rand_letter();
        return ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 25))
                                            : 5'($urandom_range(0, 3));
    endfunction

    task automatic test_text_before_build();
        send_item(acm_pkg::OP_TEXT, 5'd0, 1'b0);
        send_item(acm_pkg::OP_TEXT, 5'd25, 1'b1);
        send_item(acm_pkg::OP_TEXT, 5'd31, 1'b0);
        drain();
    endtask

    task automatic test_load_patterns();
        int len;
        send_pattern("he");
        send_pattern("she");
        send_pattern("his");
        send_pattern("hers");
        send_pattern("he");
        send_pattern("a");
        send_pattern("zyx");
        // out-of-range letter with end mark: drop the whole item
        send_item(acm_pkg::OP_LOAD, 5'd7, 1'b0);
        send_item(acm_pkg::OP_LOAD, 5'd30, 1'b1);
        send_item(acm_pkg::OP_LOAD, 5'd8, 1'b1);
        pats_loaded++;
        send_item(2'd3, 5'd1, 1'b1);
        while (pats_loaded < NPATS) begin
            len = $urandom_range(1, 2);
            for (int k = 0; k < len; k++)
                send_item(acm_pkg::OP_LOAD, rand_letter(), k == len - 1);
            pats_loaded++;
        end
        // one pattern too many, then letters that must be dropped
        send_pattern("abd");
        send_item(acm_pkg::OP_LOAD, 5'd2, 1'b0);
        send_item(acm_pkg::OP_LOAD, 5'd3, 1'b1);
        drain();
    endtask

    task automatic test_build();
        send_item(acm_pkg::OP_BUILD, 5'd0, 1'b0);
        send_item(acm_pkg::OP_BUILD, 5'd31, 1'b1);
        send_item(acm_pkg::OP_LOAD, 5'd0, 1'b1);
        drain();
    endtask

    task automatic test_directed_text();
        send_text("ushers");
        send_item(acm_pkg::OP_TEXT, 5'd26, 1'b0);
        send_text("ahishe");
        send_item(2'd3, 5'd0, 1'b0);
        send_text("zyxaaab");
        drain();
    endtask

    task automatic test_output_hold();
        hold_req = 1;
        for (int k = 0; k < 30; k++)
            send_item(acm_pkg::OP_TEXT, 5'($urandom_range(0, 3)), 1'b0);
        drain();
    endtask

    task automatic test_random_text();
        int r;
        for (int k = 0; k < 100; k++) begin
            if (k == 70) quiet = 1;
            r = $urandom_range(0, 99);
            if (r < 4)
                send_item(acm_pkg::OP_TEXT, 5'($urandom_range(26, 31)), 1'($urandom));
            else if (r < 6)
                send_item(2'd3, 5'($urandom), 1'($urandom));
            else if (r < 8)
                send_item(acm_pkg::OP_LOAD, 5'($urandom), 1'($urandom));
            else if (r < 9)
                send_item(acm_pkg::OP_BUILD, 5'($urandom), 1'($urandom));
            else
                send_item(acm_pkg::OP_TEXT, rand_letter(), 1'($urandom));
        end
        drain();
    endtask

    initial begin
        err_cnt = 0; pats_loaded = 0; quiet = 0; hold_req = 0;
        clear_automaton();
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_opcode      <= acm_pkg::OP_LOAD;
        i_char_code   <= 5'd0;
        i_pattern_end <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_text_before_build();
        test_load_patterns();
        test_build();
        test_directed_text();
        test_output_hold();
        test_random_text();

        repeat (50) @(posedge i_clk);
        if (err_cnt == 0 && match_q.size() == 0)
            $display("** aho_corasick_multi_pattern_matcher: PASSED **");
        else
            $display("** aho_corasick_multi_pattern_matcher: FAILED **");
        $finish;
    end

endmodule
